// File: src/iaf_pkg.sv
package iaf_pkg;

    // Decimal digits needed for the largest 64-bit value
    localparam int unsigned NDIG   = 20;
    localparam int unsigned ND_W   = $clog2(NDIG + 1);
    localparam int unsigned BCD_W  = 4 * NDIG;
    localparam int unsigned VAL_W  = 64;
    localparam int unsigned STEP_W = $clog2(VAL_W);

    localparam logic [1:0] FMT_SDEC = 2'd0;
    localparam logic [1:0] FMT_UDEC = 2'd1;
    localparam logic [1:0] FMT_HEX  = 2'd2;
    localparam int unsigned FMT_HEX_BIT = 1;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [1:0]       format;
        logic             zero_pad;
        logic [5:0]       width;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic load_hex;
        logic load_dec;
        logic step;
        logic shift;
    } t_unit_ctl;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else begin
            c = CH_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// File: src/integer_to_ascii_formatter.sv
// Hex values load straight into the digit unit, then leading zero digits are dropped before sign and pad;
// decimal adds 64 double-dabble steps, one input bit per cycle through the shared BCD unit.
// Then one character per cycle while the output is taken; no character goes out on the step from pad to digits.
// One number at a time: a new number is accepted only when the sequencer is back in idle.
// Reset (synchronous, active low) returns the sequencer to idle and drops the output word.
module integer_to_ascii_formatter
    import iaf_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 63
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam logic [5:0] LP_MAX = 6'(MAX_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_NORM,
        S_SIGN,
        S_PAD,
        S_DIG
    } t_state;

    t_state          r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [ND_W-1:0] r_nd, n_nd;
    logic [5:0]      r_width, n_width;
    logic            r_neg, n_neg;
    logic            r_zpad, n_zpad;
    logic            r_o_valid, n_o_valid;
    t_out_item       r_o_item, n_o_item;

    t_unit_ctl       w_ctl;
    logic [VAL_W-1:0] w_load_val;
    logic [3:0]      w_top;
    logic            w_free;
    logic            w_accept;
    logic            w_is_hex;
    logic            w_neg_in;
    logic [5:0]      w_wsat;

    iaf_digit_unit u_digit (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_load_val (w_load_val),
        .o_top_digit(w_top)
    );

    assign w_free   = !r_o_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_is_hex = i_item.format[FMT_HEX_BIT];
    assign w_neg_in = (i_item.format == FMT_SDEC) && i_item.value[VAL_W-1];
    assign w_wsat   = (i_item.width > LP_MAX) ? LP_MAX : i_item.width;
    assign w_load_val = w_neg_in ? (VAL_W'(0) - i_item.value) : i_item.value;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_nd      = r_nd;
        n_width   = r_width;
        n_neg     = r_neg;
        n_zpad    = r_zpad;
        n_o_valid = r_o_valid && !i_ready;
        n_o_item  = r_o_item;
        w_ctl     = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_ctl.load_hex = w_is_hex;
                    w_ctl.load_dec = !w_is_hex;
                    n_neg   = w_neg_in;
                    n_zpad  = i_item.zero_pad;
                    n_width = (w_neg_in && w_wsat != 6'd0) ? w_wsat - 6'd1 : w_wsat;
                    n_cnt   = '0;
                    n_nd    = ND_W'(NDIG);
                    n_state = w_is_hex ? S_NORM : S_CONV;
                end
            end
            S_CONV: begin
                w_ctl.step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(VAL_W - 1)) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                // drop leading zero digits, keep at least one
                if (w_top == 4'd0 && r_nd > ND_W'(1)) begin
                    w_ctl.shift = 1'b1;
                    n_nd = r_nd - 1'b1;
                end else begin
                    n_state = r_neg ? S_SIGN : S_PAD;
                end
            end
            S_SIGN: begin
                if (w_free) begin
                    n_o_valid = 1'b1;
                    n_o_item  = '{out_char: CH_MINUS, last: 1'b0};
                    n_state   = S_PAD;
                end
            end
            S_PAD: begin
                if (r_width > {{(6-ND_W){1'b0}}, r_nd}) begin
                    if (w_free) begin
                        n_o_valid = 1'b1;
                        n_o_item  = '{out_char: (r_zpad ? CH_ZERO : CH_SPACE), last: 1'b0};
                        n_width   = r_width - 6'd1;
                    end
                end else begin
                    n_state = S_DIG;
                end
            end
            S_DIG: begin
                if (w_free) begin
                    w_ctl.shift = 1'b1;
                    n_o_valid = 1'b1;
                    n_o_item  = '{out_char: digit_char(w_top), last: (r_nd == ND_W'(1))};
                    n_nd      = r_nd - 1'b1;
                    if (r_nd == ND_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_cnt    <= n_cnt;
        r_nd     <= n_nd;
        r_width  <= n_width;
        r_neg    <= n_neg;
        r_zpad   <= n_zpad;
        r_o_item <= n_o_item;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_o_valid;
    assign o_item  = r_o_item;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("accepted a word but stayed ready");

    a_digits_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG || r_state == S_PAD) |-> r_nd != '0)
        else $error("digit count ran out while emitting");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG && w_free && r_nd == ND_W'(1))
            |=> (o_valid && o_item.last && r_state == S_IDLE))
        else $error("final digit not flagged last");

    a_nd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> r_nd <= ND_W'(NDIG))
        else $error("digit count out of range");
`endif

endmodule

// File: src/iaf_digit_unit.sv
module iaf_digit_unit
    import iaf_pkg::*;
(
    input  logic             i_clk,
    input  t_unit_ctl        i_ctl,
    input  logic [VAL_W-1:0] i_load_val,
    output logic [3:0]       o_top_digit
);

    logic [VAL_W-1:0] r_bin;
    logic [BCD_W-1:0] r_bcd;
    logic [BCD_W-1:0] n_adj;

    // add 3 to every BCD digit of 5 or more before the doubling shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_hex) begin
            r_bcd <= {{(BCD_W-VAL_W){1'b0}}, i_load_val};
            r_bin <= i_load_val;
        end else if (i_ctl.load_dec) begin
            r_bcd <= '0;
            r_bin <= i_load_val;
        end else if (i_ctl.step) begin
            r_bcd <= {n_adj[BCD_W-2:0], r_bin[VAL_W-1]};
            r_bin <= {r_bin[VAL_W-2:0], 1'b0};
        end else if (i_ctl.shift) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
        end
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: 4];

endmodule

// File: tb/integer_to_ascii_formatter_chk.sv
module integer_to_ascii_formatter_chk
    import iaf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_word,
    output int        o_fail_count,
    output int        o_chars_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_FIELD  = 63;

    t_out_item exp_chars[$];
    t_out_item want;
    int        fail_count = 0;

    // Build the character string for one number and queue it, last flag on the final one.
    function automatic void queue_number_chars(input t_in_item w);
        logic [63:0] mag;
        logic [63:0] radix;
        logic [63:0] rem;
        logic [7:0]  digs[0:23];
        logic [7:0]  txt[$];
        int          ndig;
        int          field;
        int          i;
        t_out_item   c;

        mag   = w.value;
        radix = w.format[FMT_HEX_BIT] ? 64'd16 : 64'd10;
        field = (w.width > MAX_FIELD) ? int'(MAX_FIELD) : int'(w.width);
        ndig  = 0;

        // Sign counts against the field width; magnitude wraps for the most negative value.
        if (w.format == FMT_SDEC && mag[63]) begin
            txt.push_back(CH_MINUS);
            mag = 64'd0 - mag;
            if (field > 0) field--;
        end

        do begin
            rem = mag % radix;
            digs[ndig] = (rem < 64'd10) ? CH_ZERO + rem[7:0] : CH_A + rem[7:0] - 8'd10;
            ndig++;
            mag = mag / radix;
        end while (mag != 64'd0);

        while (ndig < field) begin
            txt.push_back(w.zero_pad ? CH_ZERO : CH_SPACE);
            field--;
        end

        for (i = ndig - 1; i >= 0; i--) txt.push_back(digs[i]);

        for (i = 0; i < txt.size(); i++) begin
            c.out_char = txt[i];
            c.last     = (i == txt.size() - 1);
            exp_chars.push_back(c);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) queue_number_chars(i_in_word);

            if (i_out_valid && i_out_ready) begin
                if (exp_chars.size() == 0) begin
                    fail_count++;
                    $display("%0t unexpected word: expected none, got char %h last %b",
                             $realtime, i_out_word.out_char, i_out_word.last);
                end else begin
                    want = exp_chars.pop_front();
                    if (i_out_word.out_char !== want.out_char ||
                        i_out_word.last !== want.last) begin
                        fail_count++;
                        $display("%0t mismatch: expected char %h last %b, got char %h last %b",
                                 $realtime, want.out_char, want.last,
                                 i_out_word.out_char, i_out_word.last);
                    end
                end
            end
        end
        o_fail_count    <= fail_count;
        o_chars_pending <= exp_chars.size();
    end

endmodule

// File: tb/tb_top.sv
module tb_top
    import iaf_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FMT_HEX_ALT = 2'd3;
    localparam int         N_RANDOM    = 188;
    localparam int         CYCLE_LIMIT = 1_500_000;
    localparam int         TAIL_CYCLES = 200;

    logic      i_clk;
    logic      i_rst_n  = 1'b0;
    logic      i_valid  = 1'b0;
    logic      o_ready;
    t_in_item  i_item   = '0;
    logic      o_valid;
    logic      i_ready  = 1'b0;
    t_out_item o_item;

    int fail_count;
    int chars_pending;
    int cycle_count = 0;
    int burst_left  = 0;
    int rx_mode     = 0;
    int rx_left     = 0;
    int rx_count    = 0;

    integer_to_ascii_formatter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    integer_to_ascii_formatter_chk chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_in_word       (i_item),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_out_word      (o_item),
        .o_fail_count    (fail_count),
        .o_chars_pending (chars_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL integer_to_ascii_formatter");
            $finish;
        end
    end

    // Receiver: switch between always ready, coin flip, fixed pattern and mostly stalled.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(50, 400);
        end
        rx_left--;
        rx_count++;
        case (rx_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= (rx_count % 5) != 0;
            default: i_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Hold valid until the word is taken, then keep the burst going or idle a while.
    task automatic send_word(input t_in_item w);
        i_valid <= 1'b1;
        i_item  <= w;
        do @(posedge i_clk); while (!o_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic send_fmt(input logic [63:0] v, input logic [1:0] f,
                            input logic zp, input logic [5:0] w);
        t_in_item word;
        word.value    = v;
        word.format   = f;
        word.zero_pad = zp;
        word.width    = w;
        send_word(word);
    endtask

    // Drop valid and wait until every queued character has come out.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (chars_pending != 0);
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        logic [63:0] p;
        int          k;
        case ($urandom_range(0, 5))
            0: v = 64'($urandom_range(0, 999));
            1: v = {$urandom, $urandom};
            2: begin
                p = 64'd1;
                k = $urandom_range(0, 19);
                repeat (k) p = p * 64'd10;
                v = p - 64'd1 + 64'($urandom_range(0, 2));
            end
            3: begin
                k = $urandom_range(0, 63);
                v = (64'd1 << k) - 64'd1 + 64'($urandom_range(0, 2));
            end
            4: v = 64'd0 - 64'($urandom_range(1, 100000));
            default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        return v;
    endfunction

    initial begin
        int n;
        logic [5:0] w;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_fmt(64'd0, FMT_SDEC, 1'b0, 6'd0);
        send_fmt(64'd0, FMT_HEX, 1'b1, 6'd5);
        send_fmt(64'hFFFF_FFFF_FFFF_FFFF, FMT_UDEC, 1'b0, 6'd0);
        send_fmt(64'hFFFF_FFFF_FFFF_FFFF, FMT_SDEC, 1'b0, 6'd0);
        send_fmt(64'hFFFF_FFFF_FFFF_FFFF, FMT_HEX, 1'b0, 6'd63);
        // most negative value: magnitude wraps
        send_fmt(64'h8000_0000_0000_0000, FMT_SDEC, 1'b0, 6'd0);
        send_fmt(64'h8000_0000_0000_0000, FMT_SDEC, 1'b1, 6'd25);
        send_fmt(64'h8000_0000_0000_0000, FMT_UDEC, 1'b1, 6'd0);
        send_fmt(64'h7FFF_FFFF_FFFF_FFFF, FMT_SDEC, 1'b1, 6'd63);
        send_fmt(64'hDEAD_BEEF_0123_4567, FMT_HEX_ALT, 1'b1, 6'd20);
        send_fmt(64'h0000_0000_00AB_CDEF, FMT_HEX_ALT, 1'b0, 6'd10);
        send_fmt(64'd123456, FMT_UDEC, 1'b1, 6'd3);
        send_fmt(64'd0 - 64'd5, FMT_SDEC, 1'b1, 6'd0);
        send_fmt(64'd0 - 64'd5, FMT_SDEC, 1'b1, 6'd1);
        send_fmt(64'd0 - 64'd5, FMT_SDEC, 1'b1, 6'd4);
        send_fmt(64'd0 - 64'd5, FMT_SDEC, 1'b0, 6'd4);
        send_fmt(64'd0 - 64'd5, FMT_UDEC, 1'b0, 6'd2);
        send_fmt(64'd1, FMT_UDEC, 1'b1, 6'd63);
        send_fmt(64'd9999999999999999999, FMT_UDEC, 1'b0, 6'd21);
        send_fmt(64'd10000000000000000000, FMT_UDEC, 1'b0, 6'd20);
        send_fmt(64'h5555_5555_5555_5555, FMT_HEX, 1'b0, 6'd17);
        send_fmt(64'hAAAA_AAAA_AAAA_AAAA, FMT_SDEC, 1'b0, 6'd22);
        hold_until_drained();

        for (n = 0; n < N_RANDOM; n++) begin
            w = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 24));
            send_fmt(pick_value(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), w);
            if (n % 70 == 69) hold_until_drained();
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && chars_pending == 0) begin
            $display("PASS integer_to_ascii_formatter");
        end else begin
            $display("FAIL integer_to_ascii_formatter");
        end
        $finish;
    end

endmodule
